/* hw/rtl/srsw_pkg.sv */
// srsw_pkg: shared types and codes for the selective-repeat sender window.
// Used by srsw_ctrl, srsw_dp and selective_repeat_sender_window; no dependencies.
package srsw_pkg;

  // Field widths fixed by the interface
  localparam int REQ_W  = 2;
  localparam int KIND_W = 2;
  localparam int SEQ_W  = 8;
  localparam int BASE_W = 9;
  localparam int WS_W   = 5;
  localparam int TOT_W  = 9;
  localparam int CFG_W  = 9;
  localparam int CFG_IDX_W = 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_FILL    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

  // Config register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 1'd1;
  localparam logic [WS_W-1:0]      WS_RST  = 5'd4;
  localparam logic [TOT_W-1:0]     TOT_RST = 9'd9;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;     // latch request, start scan at base, drop held result
    logic fill_step;   // emit next new seq, clear its bitmap entry, advance
    logic emit_hold;   // emit the held result (status if none held)
    logic emit_last;   // last flag for the beat emitted this cycle
    logic ack_mark;    // set bitmap entry of the acked seq
    logic set_reject;  // hold a rejected-ack result
    logic set_scan;    // hold a retransmit of the scan pointer
    logic rd_base;     // read bitmap at window base
    logic base_inc;    // advance window base
    logic rd_scan;     // read bitmap at scan pointer
    logic scan_inc;    // advance scan pointer
  } srsw_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic fill_ok;
    logic fill_next_ok;
    logic ack_bad;
    logic base_ok;
    logic scan_ok;
    logic rd_bit;
    logic hold_valid;
    logic slot_free;
  } srsw_sts_t;

endpackage

/* hw/rtl/srsw_ctrl.sv */
// srsw_ctrl: sequencing state machine for the sender window.
// Depends on srsw_pkg; drives srsw_dp through command/status structs.
module srsw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  srsw_pkg::srsw_sts_t   sts,
  output srsw_pkg::srsw_cmd_t   cmd
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DISPATCH = 7'b0000010,
    ST_FILL     = 7'b0000100,
    ST_BASE_RD  = 7'b0001000,
    ST_BASE_CHK = 7'b0010000,
    ST_SCAN_RD  = 7'b0100000,
    ST_SCAN_CHK = 7'b1000000
  } state_t;

  // ST_FINAL folded in as a one-hot code of its own below
  typedef enum logic [1:0] {
    FIN_NONE = 2'b01,
    FIN_WAIT = 2'b10
  } fin_t;

  state_t state_r, state_nxt;
  fin_t   fin_r, fin_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    fin_nxt   = fin_r;
    in_stall  = !((state_r == ST_IDLE) && (fin_r == FIN_NONE));

    if (fin_r == FIN_WAIT) begin
      // final beat of the item: held result, or status when nothing is held
      if (sts.slot_free) begin
        cmd.emit_hold = 1'b1;
        cmd.emit_last = 1'b1;
        fin_nxt       = FIN_NONE;
        state_nxt     = ST_IDLE;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          case (sts.req)
            srsw_pkg::REQ_FILL:    state_nxt = ST_FILL;
            srsw_pkg::REQ_ACK: begin
              if (sts.ack_bad) begin
                cmd.set_reject = 1'b1;
                fin_nxt        = FIN_WAIT;
              end else begin
                cmd.ack_mark = 1'b1;
                state_nxt    = ST_BASE_RD;
              end
            end
            srsw_pkg::REQ_TIMEOUT: state_nxt = ST_SCAN_RD;
            default:               fin_nxt   = FIN_WAIT;
          endcase
        end
        ST_FILL: begin
          if (!sts.fill_ok) begin
            fin_nxt = FIN_WAIT;
          end else if (sts.slot_free) begin
            cmd.fill_step = 1'b1;
            cmd.emit_last = !sts.fill_next_ok;
            if (!sts.fill_next_ok) begin
              state_nxt = ST_IDLE;
            end
          end
        end
        ST_BASE_RD: begin
          if (sts.base_ok) begin
            cmd.rd_base = 1'b1;
            state_nxt   = ST_BASE_CHK;
          end else begin
            fin_nxt = FIN_WAIT;
          end
        end
        ST_BASE_CHK: begin
          if (sts.rd_bit) begin
            cmd.base_inc = 1'b1;
            state_nxt    = ST_BASE_RD;
          end else begin
            fin_nxt = FIN_WAIT;
          end
        end
        ST_SCAN_RD: begin
          if (sts.scan_ok) begin
            cmd.rd_scan = 1'b1;
            state_nxt   = ST_SCAN_CHK;
          end else begin
            fin_nxt = FIN_WAIT;
          end
        end
        ST_SCAN_CHK: begin
          if (sts.rd_bit) begin
            cmd.scan_inc = 1'b1;
            state_nxt    = ST_SCAN_RD;
          end else if (!sts.hold_valid) begin
            cmd.set_scan = 1'b1;
            cmd.scan_inc = 1'b1;
            state_nxt    = ST_SCAN_RD;
          end else if (sts.slot_free) begin
            // older candidate goes out, newer one takes its place
            cmd.emit_hold = 1'b1;
            cmd.set_scan  = 1'b1;
            cmd.scan_inc  = 1'b1;
            state_nxt     = ST_SCAN_RD;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= FIN_NONE;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

/* hw/rtl/srsw_dp.sv */
// srsw_dp: window registers, config, acked bitmap memory and output register.
// Depends on srsw_pkg; commanded by srsw_ctrl.
module srsw_dp #(
  parameter int MAX_PACKETS = 256,
  parameter int MAX_WINDOW  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [srsw_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [srsw_pkg::REQ_W-1:0]        in_req_type,
  input  logic [srsw_pkg::SEQ_W-1:0]        in_ack_seq,
  input  logic                              out_stall,
  input  srsw_pkg::srsw_cmd_t               cmd,
  output srsw_pkg::srsw_sts_t               sts,
  output logic                              out_valid,
  output logic [srsw_pkg::KIND_W-1:0]       out_result_kind,
  output logic [srsw_pkg::SEQ_W-1:0]        out_seq,
  output logic [srsw_pkg::BASE_W-1:0]       out_window_base,
  output logic                              out_all_done,
  output logic                              out_last
);

  localparam int PW = $clog2(MAX_PACKETS + 1);
  localparam int AW = $clog2(MAX_PACKETS);
  localparam int SW = ((PW > srsw_pkg::BASE_W) ? PW : srsw_pkg::BASE_W) + 1;
  localparam logic [SW-1:0] MAXP = SW'(MAX_PACKETS);
  localparam logic [SW-1:0] MAXW = SW'(MAX_WINDOW);

  logic [srsw_pkg::WS_W-1:0]   ws_cfg_r;
  logic [srsw_pkg::TOT_W-1:0]  tot_cfg_r;
  logic [PW-1:0]               base_r, nns_r;
  logic [SW-1:0]               scan_r;
  logic [srsw_pkg::REQ_W-1:0]  req_r;
  logic [srsw_pkg::SEQ_W-1:0]  ack_r;
  logic                        hold_valid_r;
  logic [srsw_pkg::KIND_W-1:0] hold_kind_r;
  logic [srsw_pkg::SEQ_W-1:0]  hold_seq_r;
  logic                        rd_bit_r;
  logic                        out_valid_r, out_last_r, out_done_r;
  logic [srsw_pkg::KIND_W-1:0] out_kind_r;
  logic [srsw_pkg::SEQ_W-1:0]  out_seq_r;
  logic [srsw_pkg::BASE_W-1:0] out_base_r;

  logic ack_map_mem [MAX_PACKETS];

  logic [SW-1:0] eff_w, eff_tot, base_ext, nns_ext, nns_inc, lim, ack_ext;
  logic          mem_we, mem_wd, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic          slot_free;

  always_comb begin
    eff_w    = (SW'(ws_cfg_r) > MAXW) ? MAXW : SW'(ws_cfg_r);
    eff_tot  = (SW'(tot_cfg_r) > MAXP) ? MAXP : SW'(tot_cfg_r);
    base_ext = SW'(base_r);
    nns_ext  = SW'(nns_r);
    nns_inc  = nns_ext + SW'(1);
    lim      = base_ext + eff_w;
    ack_ext  = SW'(ack_r);
    slot_free = !out_valid_r || !out_stall;

    sts.req          = req_r;
    sts.fill_ok      = (nns_ext < lim) && (nns_ext < eff_tot);
    sts.fill_next_ok = (nns_inc < lim) && (nns_inc < eff_tot);
    sts.ack_bad      = (ack_ext >= nns_ext) || (ack_ext >= MAXP);
    // entries at or past the next new seq were never acked since reset
    sts.base_ok      = (base_ext < eff_tot) && (base_ext < MAXP) && (base_ext < nns_ext);
    sts.scan_ok      = (scan_r < nns_ext) && (scan_r < lim) && (scan_r < MAXP);
    sts.rd_bit       = rd_bit_r;
    sts.hold_valid   = hold_valid_r;
    sts.slot_free    = slot_free;

    // sending a packet clears its entry, so stale contents never show
    mem_we = cmd.fill_step || cmd.ack_mark;
    mem_wd = cmd.ack_mark;
    mem_wa = cmd.ack_mark ? ack_ext[AW-1:0] : nns_r[AW-1:0];
    mem_re = cmd.rd_base || cmd.rd_scan;
    mem_ra = cmd.rd_scan ? scan_r[AW-1:0] : base_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ack_map_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_bit_r <= ack_map_mem[mem_ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_cfg_r     <= srsw_pkg::WS_RST;
      tot_cfg_r    <= srsw_pkg::TOT_RST;
      base_r       <= '0;
      nns_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          srsw_pkg::CFG_WINDOW_SIZE:   ws_cfg_r  <= cfg_wdata[srsw_pkg::WS_W-1:0];
          srsw_pkg::CFG_TOTAL_PACKETS: tot_cfg_r <= cfg_wdata[srsw_pkg::TOT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.base_inc) begin
        base_r <= base_r + PW'(1);
      end
      if (cmd.fill_step) begin
        nns_r <= nns_r + PW'(1);
      end
      if (cmd.capture) begin
        hold_valid_r <= 1'b0;
      end else if (cmd.set_reject || cmd.set_scan) begin
        hold_valid_r <= 1'b1;
      end
      if (cmd.fill_step || cmd.emit_hold) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      ack_r  <= in_ack_seq;
      scan_r <= base_ext;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + SW'(1);
    end
    if (cmd.set_reject) begin
      hold_kind_r <= srsw_pkg::KIND_REJECT;
      hold_seq_r  <= ack_r;
    end else if (cmd.set_scan) begin
      hold_kind_r <= srsw_pkg::KIND_RETX;
      hold_seq_r  <= scan_r[srsw_pkg::SEQ_W-1:0];
    end
    if (cmd.fill_step || cmd.emit_hold) begin
      out_base_r <= base_ext[srsw_pkg::BASE_W-1:0];
      out_done_r <= base_ext >= eff_tot;
      out_last_r <= cmd.emit_last;
      if (cmd.fill_step) begin
        out_kind_r <= srsw_pkg::KIND_NEW;
        out_seq_r  <= nns_ext[srsw_pkg::SEQ_W-1:0];
      end else begin
        out_kind_r <= hold_valid_r ? hold_kind_r : srsw_pkg::KIND_STATUS;
        out_seq_r  <= hold_valid_r ? hold_seq_r : '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_seq         = out_seq_r;
  assign out_window_base = out_base_r;
  assign out_all_done    = out_done_r;
  assign out_last        = out_last_r;

endmodule

/* hw/rtl/selective_repeat_sender_window.sv */
// selective_repeat_sender_window: top level of the selective-repeat sender window.
// Depends on srsw_pkg, srsw_ctrl and srsw_dp.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one request per beat: fill (send
//   every new seq the window and packet total allow), ack (mark in_ack_seq and
//   slide the base), or timeout (resend every unacked sent seq in the window).
//   Output channel (out_valid/out_stall) gives one or more result beats per
//   request; out_last marks the final one. A request with nothing to send
//   gives a single status beat; an ack of an unsent seq gives a reject beat.
//   cfg_we/cfg_idx/cfg_wdata write window_size (0) and total_packets (1);
//   write only while idle. Config writes never touch the window state.
// Sequencing: one request at a time. The bitmap walk has one read port with a
//   registered read: each entry is read in a *_RD state, checked in a *_CHK state.
// Reset (rst_n low, synchronous): base and next seq go to 0, config to 4 and
//   9. The bitmap needs no clearing pass: an entry is zeroed when its packet
//   is first sent, and entries at or past the next new seq read as unacked.
// Stall: a held output beat stays put while out_stall is high; the walk
//   pauses at its next emit. in_stall stays high until the last beat is
//   registered, and a new request may be taken while that beat still waits.
module selective_repeat_sender_window #(
  parameter int MAX_PACKETS = 256,
  parameter int MAX_WINDOW  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [srsw_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [srsw_pkg::REQ_W-1:0]        in_req_type,
  input  logic [srsw_pkg::SEQ_W-1:0]        in_ack_seq,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [srsw_pkg::KIND_W-1:0]       out_result_kind,
  output logic [srsw_pkg::SEQ_W-1:0]        out_seq,
  output logic [srsw_pkg::BASE_W-1:0]       out_window_base,
  output logic                              out_all_done,
  output logic                              out_last
);

  // command/status link between sequencer and datapath
  srsw_pkg::srsw_cmd_t cmd;
  srsw_pkg::srsw_sts_t sts;

  // sequencer: one request at a time, walks the bitmap through the datapath
  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: window pointers, config, bitmap memory, output beat register
  srsw_dp #(
    .MAX_PACKETS (MAX_PACKETS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_req_type),
    .in_ack_seq      (in_ack_seq),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_seq         (out_seq),
    .out_window_base (out_window_base),
    .out_all_done    (out_all_done),
    .out_last        (out_last)
  );

endmodule
